// ===== rtl/ttb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeout timer bank package
// Shared constants, operation codes, controller states and memory types.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int unsigned TimerCountDef = 8;
  localparam int unsigned ModeW         = 2;
  localparam int unsigned IdW           = 3;
  localparam int unsigned TicksW        = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK    = 2'd0,
    MODE_ARM     = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_KILL    = 2'd3
  } ttb_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ttb_state_e;

  typedef struct packed {
    logic [TicksW-1:0] cnt;
    logic [TicksW-1:0] lim;
  } ttb_entry_t;

  typedef struct packed {
    logic cnt;
    logic lim;
  } ttb_wen_t;

endpackage

// ===== rtl/ttb_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeout timer bank command channel
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface ttb_cmd_if
  import ttb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [IdW-1:0]    timer_id;
  logic [TicksW-1:0] deadline;

  modport source (output valid, mode, timer_id, deadline, input ready);
  modport sink   (input valid, mode, timer_id, deadline, output ready);
endinterface

// ===== rtl/ttb_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeout timer bank response channel
// Valid/ready channel that carries the flags of the addressed timer.
// ----------------------------------------------------------------------------
interface ttb_rsp_if;
  logic valid;
  logic ready;
  logic expired;
  logic running;

  modport source (output valid, expired, running, input ready);
  modport sink   (input valid, expired, running, output ready);
endinterface

// ===== rtl/ttb_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeout timer bank store
// Count and deadline memories with one write port each and a shared,
// registered read port.
// ----------------------------------------------------------------------------
module ttb_store
  import ttb_pkg::*;
#(
  parameter int unsigned TIMER_COUNT = TimerCountDef,
  localparam int unsigned IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output ttb_entry_t      rd_data_o,
  input  ttb_wen_t        wen_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  ttb_entry_t      wr_data_i
);

  logic [TicksW-1:0] cnt_mem [TIMER_COUNT];
  logic [TicksW-1:0] lim_mem [TIMER_COUNT];
  ttb_entry_t        rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wen_i.cnt) begin
      cnt_mem[wr_idx_i] <= wr_data_i.cnt;
    end
    if (wen_i.lim) begin
      lim_mem[wr_idx_i] <= wr_data_i.lim;
    end
    if (rd_en_i) begin
      rd_data_q.cnt <= cnt_mem[rd_idx_i];
      rd_data_q.lim <= lim_mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/timeout_timer_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeout timer bank
// Arm, restart, kill and tick a bank of timeout timers held in memory.
// ----------------------------------------------------------------------------
// One command word is taken at a time and answered with one response word
// holding the expired and running flags of the addressed timer. Arm, restart
// and kill pass an apply state and then a done state. A tick walks the count
// and deadline memories one timer per cycle through a read and a write-back
// stage, then drains. A finished response waits in an output register, and
// the next command is accepted meanwhile.
module timeout_timer_bank
  import ttb_pkg::*;
#(
  parameter int unsigned TIMER_COUNT = TimerCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ttb_cmd_if.sink     cmd_i,
  ttb_rsp_if.source   rsp_o
);

  localparam int unsigned IdxW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned CmpW = IdW + IdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TIMER_COUNT - 1);

  ttb_state_e        state_q, state_d;
  ttb_mode_e         mode_q;
  logic [IdW-1:0]    id_q;
  logic [TicksW-1:0] dl_q;

  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic              wb_vld_q, wb_vld_d;
  logic [IdxW-1:0]   wb_idx_q;
  logic [TIMER_COUNT-1:0] started_q, started_d;
  logic [TIMER_COUNT-1:0] expired_q, expired_d;

  logic              rsp_valid_q;
  logic              rsp_exp_q, rsp_run_q;
  logic              rsp_load;

  logic              cmd_acc;
  logic              id_ok;
  logic [IdxW-1:0]   id_idx;

  logic              rd_en;
  ttb_entry_t        rd_data;
  ttb_wen_t          wen;
  logic [IdxW-1:0]   wr_idx;
  ttb_entry_t        wr_data;
  logic [TicksW:0]   cnt_inc;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign id_ok       = CmpW'(id_q) < CmpW'(TIMER_COUNT);
  assign id_idx      = IdxW'(id_q);
  assign cnt_inc     = {1'b0, rd_data.cnt} + (TicksW + 1)'(1);

  ttb_store #(
    .TIMER_COUNT(TIMER_COUNT)
  ) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx_q),
    .rd_data_o(rd_data),
    .wen_i    (wen),
    .wr_idx_i (wr_idx),
    .wr_data_i(wr_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          state_d = (ttb_mode_e'(cmd_i.mode) == MODE_TICK) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_DONE;
      ST_SCAN: begin
        if (rd_idx_q == LastIdx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    rd_idx_d  = rd_idx_q;
    wb_vld_d  = 1'b0;
    wen       = '0;
    wr_idx    = wb_idx_q;
    wr_data   = '0;
    started_d = started_q;
    expired_d = expired_q;
    rsp_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        rd_idx_d = '0;
      end
      ST_APPLY: begin
        wr_idx = id_idx;
        if (id_ok) begin
          unique case (mode_q)
            MODE_ARM: begin
              wen               = '{cnt: 1'b1, lim: 1'b1};
              wr_data.lim       = dl_q;
              started_d[id_idx] = 1'b1;
              expired_d[id_idx] = 1'b0;
            end
            MODE_RESTART: begin
              wen.cnt           = 1'b1;
              expired_d[id_idx] = 1'b0;
            end
            MODE_KILL: begin
              started_d[id_idx] = 1'b0;
              expired_d[id_idx] = 1'b0;
            end
            MODE_TICK: ;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        rd_en    = 1'b1;
        wb_vld_d = 1'b1;
        rd_idx_d = rd_idx_q + IdxW'(1);
      end
      ST_DRAIN: ;
      ST_DONE: begin
        rsp_load = !rsp_valid_q || rsp_o.ready;
      end
      default: ;
    endcase

    // Write-back stage of the tick walk; only started timers move.
    if (wb_vld_q && started_q[wb_idx_q]) begin
      wen.cnt = 1'b1;
      wr_idx  = wb_idx_q;
      if (cnt_inc >= {1'b0, rd_data.lim}) begin
        wr_data.cnt         = rd_data.lim;
        expired_d[wb_idx_q] = 1'b1;
      end else begin
        wr_data.cnt         = cnt_inc[TicksW-1:0];
        expired_d[wb_idx_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_idx_q    <= '0;
      wb_vld_q    <= 1'b0;
      started_q   <= '0;
      expired_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      wb_vld_q  <= wb_vld_d;
      started_q <= started_d;
      expired_q <= expired_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      mode_q <= ttb_mode_e'(cmd_i.mode);
      id_q   <= cmd_i.timer_id;
      dl_q   <= cmd_i.deadline;
    end
    wb_idx_q <= rd_idx_q;
    if (rsp_load) begin
      rsp_exp_q <= id_ok && expired_q[id_idx];
      rsp_run_q <= id_ok && started_q[id_idx];
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.expired = rsp_exp_q;
  assign rsp_o.running = rsp_run_q;

  a_expired_needs_started : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (expired_q & ~started_q) == '0
  ) else $error("A timer is expired without being started.");

  a_wb_only_in_walk : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    wb_vld_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN)
  ) else $error("Tick write-back outside the timer walk.");

  a_wb_follows_read : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    wb_vld_q |-> wb_idx_q == $past(rd_idx_q)
  ) else $error("Write-back index does not match the read issued before.");

  a_accept_leaves_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |=> state_q != ST_IDLE
  ) else $error("Controller stayed idle after taking a command word.");

endmodule

// ===== sim/timeout_timer_bank_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeout timer bank testbench
// Drives arm, restart, kill and tick words and checks each response word
// against a local model of the timer bank.
// ----------------------------------------------------------------------------
// A directed sequence comes first. It covers zero and full-range deadlines,
// expiry and hold at the deadline, restart after expiry, and kill, on the
// first and last timers. Random words follow in four phases with different
// valid and ready throttling. Between phases the sender waits until every
// response has come back. Deadlines are mostly small, so timers expire often.
module timeout_timer_bank_tb;
  import ttb_pkg::*;

  localparam int unsigned TIMER_COUNT  = TimerCountDef;
  localparam int unsigned PhaseItems   = 470;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned MaxReports   = 10;

  typedef struct packed {
    ttb_mode_e         mode;
    logic [IdW-1:0]    timer_id;
    logic [TicksW-1:0] deadline;
  } timer_cmd_t;

  typedef struct packed {
    logic expired;
    logic running;
  } timer_flags_t;

  logic clk = 1'b0;
  logic rst_n;

  ttb_cmd_if cmd_if ();
  ttb_rsp_if rsp_if ();

  timeout_timer_bank #(
    .TIMER_COUNT(TIMER_COUNT)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  always #5 clk = ~clk;

  timer_cmd_t   pending_cmds[$];
  timer_flags_t expected_flags[$];

  logic [TicksW-1:0] elapsed_ticks[TIMER_COUNT];
  logic [TicksW-1:0] limit_ticks[TIMER_COUNT];
  logic              timer_started[TIMER_COUNT];
  logic              timer_expired[TIMER_COUNT];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned words_checked = 0;
  int unsigned expired_seen  = 0;
  int unsigned mode_count[4] = '{default: 0};

  function automatic timer_flags_t predict_timer_flags(ttb_mode_e mode,
                                                       logic [IdW-1:0] id,
                                                       logic [TicksW-1:0] deadline);
    timer_flags_t  flags;
    logic [TicksW:0] next_count;
    bit            id_ok;
    id_ok = (id < TIMER_COUNT);
    case (mode)
      MODE_TICK: begin
        for (int t = 0; t < TIMER_COUNT; t++) begin
          if (timer_started[t]) begin
            next_count = {1'b0, elapsed_ticks[t]} + 1'b1;
            if (next_count >= {1'b0, limit_ticks[t]}) begin
              timer_expired[t] = 1'b1;
              elapsed_ticks[t] = limit_ticks[t];
            end else begin
              timer_expired[t] = 1'b0;
              elapsed_ticks[t] = next_count[TicksW-1:0];
            end
          end
        end
      end
      MODE_ARM: begin
        if (id_ok) begin
          elapsed_ticks[id] = '0;
          limit_ticks[id]   = deadline;
          timer_started[id] = 1'b1;
          timer_expired[id] = 1'b0;
        end
      end
      MODE_RESTART: begin
        if (id_ok) begin
          elapsed_ticks[id] = '0;
          timer_expired[id] = 1'b0;
        end
      end
      default: begin
        if (id_ok) begin
          elapsed_ticks[id] = '0;
          limit_ticks[id]   = '0;
          timer_started[id] = 1'b0;
          timer_expired[id] = 1'b0;
        end
      end
    endcase
    flags.expired = id_ok ? timer_expired[id] : 1'b0;
    flags.running = id_ok ? timer_started[id] : 1'b0;
    return flags;
  endfunction

  function automatic timer_cmd_t make_cmd(ttb_mode_e mode, int unsigned id,
                                          logic [TicksW-1:0] deadline);
    timer_cmd_t cmd;
    cmd.mode     = mode;
    cmd.timer_id = id[IdW-1:0];
    cmd.deadline = deadline;
    return cmd;
  endfunction

  function automatic timer_cmd_t random_cmd();
    int unsigned pick;
    ttb_mode_e   mode;
    logic [TicksW-1:0] deadline;
    pick = $urandom_range(99);
    if (pick < 50) begin
      mode = MODE_TICK;
    end else if (pick < 70) begin
      mode = MODE_ARM;
    end else if (pick < 85) begin
      mode = MODE_RESTART;
    end else begin
      mode = MODE_KILL;
    end
    if ($urandom_range(99) < 85) begin
      deadline = $urandom_range(24);
    end else begin
      deadline = $urandom;
    end
    return make_cmd(mode, $urandom_range(TIMER_COUNT - 1), deadline);
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_flags.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Command driver: the model is updated at the edge where a word is accepted.
  always @(posedge clk or negedge rst_n) begin : drive_cmds
    timer_cmd_t   next_cmd;
    timer_flags_t flags;
    if (!rst_n) begin
      cmd_if.valid    <= 1'b0;
      cmd_if.mode     <= MODE_TICK;
      cmd_if.timer_id <= '0;
      cmd_if.deadline <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        flags = predict_timer_flags(ttb_mode_e'(cmd_if.mode), cmd_if.timer_id,
                                    cmd_if.deadline);
        expected_flags.push_back(flags);
        mode_count[cmd_if.mode]++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          cmd_if.valid    <= 1'b1;
          cmd_if.mode     <= next_cmd.mode;
          cmd_if.timer_id <= next_cmd.timer_id;
          cmd_if.deadline <= next_cmd.deadline;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Response monitor: each accepted word is compared with the oldest prediction.
  always @(posedge clk) begin : check_rsps
    timer_flags_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      words_checked++;
      if (rsp_if.expired === 1'b1) begin
        expired_seen++;
      end
      if (expected_flags.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("Unexpected response word: expired %b running %b",
                   rsp_if.expired, rsp_if.running);
        end
      end else begin
        want = expected_flags.pop_front();
        if (rsp_if.expired !== want.expired || rsp_if.running !== want.running) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("Response word %0d wrong: expected expired %b running %b, got %b %b",
                     words_checked, want.expired, want.running,
                     rsp_if.expired, rsp_if.running);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped at the cycle limit with %0d responses outstanding.",
               expected_flags.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.mode     = MODE_TICK;
    cmd_if.timer_id = '0;
    cmd_if.deadline = '0;
    rsp_if.ready    = 1'b0;
    for (int t = 0; t < TIMER_COUNT; t++) begin
      elapsed_ticks[t] = '0;
      limit_ticks[t]   = '0;
      timer_started[t] = 1'b0;
      timer_expired[t] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pending_cmds.push_back(make_cmd(MODE_TICK, 0, '0));
    pending_cmds.push_back(make_cmd(MODE_ARM, 0, '0));
    pending_cmds.push_back(make_cmd(MODE_TICK, 0, '0));
    pending_cmds.push_back(make_cmd(MODE_ARM, TIMER_COUNT - 1, '1));
    pending_cmds.push_back(make_cmd(MODE_TICK, TIMER_COUNT - 1, '0));
    pending_cmds.push_back(make_cmd(MODE_ARM, 1, 32'd1));
    pending_cmds.push_back(make_cmd(MODE_TICK, 1, '1));
    pending_cmds.push_back(make_cmd(MODE_ARM, 2, 32'd2));
    pending_cmds.push_back(make_cmd(MODE_TICK, 2, '0));
    pending_cmds.push_back(make_cmd(MODE_TICK, 2, '0));
    pending_cmds.push_back(make_cmd(MODE_TICK, 2, '0));
    pending_cmds.push_back(make_cmd(MODE_RESTART, 2, '1));
    pending_cmds.push_back(make_cmd(MODE_TICK, 2, '0));
    pending_cmds.push_back(make_cmd(MODE_RESTART, 3, '0));
    pending_cmds.push_back(make_cmd(MODE_KILL, 0, '1));
    pending_cmds.push_back(make_cmd(MODE_TICK, 0, '0));
    pending_cmds.push_back(make_cmd(MODE_KILL, TIMER_COUNT - 1, '0));
    pending_cmds.push_back(make_cmd(MODE_ARM, 5, 32'h8000_0000));
    pending_cmds.push_back(make_cmd(MODE_ARM, 6, 32'h7fff_ffff));
    pending_cmds.push_back(make_cmd(MODE_ARM, 3, 32'haaaa_aaaa));
    pending_cmds.push_back(make_cmd(MODE_ARM, 4, 32'h5555_5555));
    pending_cmds.push_back(make_cmd(MODE_TICK, 6, '0));
    pending_cmds.push_back(make_cmd(MODE_RESTART, TIMER_COUNT - 1, '0));
    pending_cmds.push_back(make_cmd(MODE_KILL, 4, '0));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        pending_cmds.push_back(random_cmd());
      end
      wait_drained();
    end

    repeat (TIMER_COUNT + 8) @(negedge clk);
    $display("Checked %0d response words: %0d ticks, %0d arms, %0d restarts, %0d kills.",
             words_checked, mode_count[MODE_TICK], mode_count[MODE_ARM],
             mode_count[MODE_RESTART], mode_count[MODE_KILL]);
    $display("Expired flag seen set in %0d responses; %0d mismatches.",
             expired_seen, fail_count);
    if (fail_count == 0 && expected_flags.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
